// ----- hdl/rmd_pkg.sv -----
// Shared constants for the running mean / deviation / reliability block.
package rmd_pkg;

  localparam int COUNT_BITS = 24;
  localparam int FRAC_BITS  = 16;

  localparam int SAMPLE_W  = 32;
  localparam int MEAN_W    = 32;
  localparam int MLD_W     = 32;
  localparam int REL_W     = 23;
  localparam int SEEN_W    = 24;

  localparam int SUM_W     = SAMPLE_W + COUNT_BITS;
  localparam int DEV_SUM_W = 56;
  localparam int REL_SUM_W = 48;
  localparam int DIFF_W    = MEAN_W + 1;

  // 100 * shift, with shift below a 32-bit mld
  localparam int PROD_W    = MLD_W + 7;
  localparam int GAIN_W    = 7 + FRAC_BITS;
  localparam logic [GAIN_W-1:0] FULL_SCORE = GAIN_W'(100) << FRAC_BITS;

  localparam int DIV_RAW_W = (SUM_W > DEV_SUM_W)
                             ? ((SUM_W > PROD_W + FRAC_BITS) ? SUM_W : PROD_W + FRAC_BITS)
                             : ((DEV_SUM_W > PROD_W + FRAC_BITS) ? DEV_SUM_W
                                                                 : PROD_W + FRAC_BITS);
  localparam int DIV_W     = ((DIV_RAW_W + 1) / 2) * 2;
  localparam int DVS_W     = 32;
  localparam int DIV_STEPS = DIV_W / 2;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

endpackage

// ----- hdl/rmd_in_if.sv -----
// Sample request channel.
interface rmd_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [rmd_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

// ----- hdl/rmd_out_if.sv -----
// Result request channel.
interface rmd_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [rmd_pkg::MEAN_W-1:0]  mean;
  logic        [rmd_pkg::MLD_W-1:0]   mean_deviation;
  logic        [rmd_pkg::REL_W-1:0]   reliability;
  logic        [rmd_pkg::SEEN_W-1:0]  samples_seen;
  logic                               count_full;

  modport source (output valid, output mean, output mean_deviation, output reliability,
                  output samples_seen, output count_full, input ready);
  modport sink   (input valid, input mean, input mean_deviation, input reliability,
                  input samples_seen, input count_full, output ready);
endinterface

// ----- hdl/rmd_div.sv -----
// Shared unsigned radix-4 restoring divider, two quotient bits per cycle.
module rmd_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [rmd_pkg::DIV_W-1:0]   dividend,
  input  logic [rmd_pkg::DVS_W-1:0]   divisor,
  output logic                        done,
  output logic [rmd_pkg::DIV_W-1:0]   quotient
);
  import rmd_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DVS_W:0]       rem, rem_next;
  logic [DIV_W-1:0]     qd, qd_next;
  logic [DVS_W-1:0]     dvs;

  always_comb begin
    rem_next = rem;
    qd_next  = qd;
    for (int i = 0; i < 2; i++) begin
      rem_next = {rem_next[DVS_W-1:0], qd_next[DIV_W-1]};
      qd_next  = {qd_next[DIV_W-2:0], 1'b0};
      if (rem_next >= {1'b0, dvs}) begin
        rem_next   = rem_next - {1'b0, dvs};
        qd_next[0] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DIV_STEPS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      qd  <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= rem_next;
      qd  <= qd_next;
    end
  end

  assign quotient = qd;

endmodule

// ----- hdl/running_mean_deviation_reliability.sv -----
// Top level: running mean, mean linear deviation and reliability tracker.
//
// Takes one signed Q16.16 sample per request and returns one result per
// request: the running mean, the mean linear deviation (mld) and a 0..100
// reliability score in Q7.16, plus the sample count. The first sample after
// reset only seeds the sum and returns zeros with a count of one. Once the
// count is all ones, samples are dropped and flagged with count_full. A
// regular sample runs five divisions back to back on one shared divider that
// retires two quotient bits per cycle (old mean, new mean, mld, reliability
// gain, reliability average), each as launch, 28 radix-4 steps and done,
// between the sequencing steps accept, deviation update, gain select, sum
// update and result load. When the shift is not below a nonzero mld, or the
// mld is zero, the gain division is skipped. First and dropped samples go
// straight from accept to result load. The sample port is ready only while
// the sequencer is idle; a finished result waits in the output register and
// the next sample is accepted meanwhile, but that sample's result, and with
// it the sample port, wait until the register is taken.
module running_mean_deviation_reliability (
  input  logic      clk,
  input  logic      rst,
  rmd_in_if.sink    samples,
  rmd_out_if.source results
);
  import rmd_pkg::*;

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_OLD_GO  = 4'd1;
  localparam logic [3:0] ST_OLD_W   = 4'd2;
  localparam logic [3:0] ST_MEAN_GO = 4'd3;
  localparam logic [3:0] ST_MEAN_W  = 4'd4;
  localparam logic [3:0] ST_DEV     = 4'd5;
  localparam logic [3:0] ST_MLD_GO  = 4'd6;
  localparam logic [3:0] ST_MLD_W   = 4'd7;
  localparam logic [3:0] ST_MUL     = 4'd8;
  localparam logic [3:0] ST_GAIN_GO = 4'd9;
  localparam logic [3:0] ST_GAIN_W  = 4'd10;
  localparam logic [3:0] ST_REL_ADD = 4'd11;
  localparam logic [3:0] ST_REL_GO  = 4'd12;
  localparam logic [3:0] ST_REL_W   = 4'd13;
  localparam logic [3:0] ST_DONE    = 4'd14;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [DEV_SUM_W-1:0]  DEV_MAX   = '1;
  localparam logic [REL_SUM_W-1:0]  REL_MAX   = '1;

  logic [3:0] state;

  // accumulated state
  logic [SUM_W-1:0]      sum_r;
  logic [DEV_SUM_W-1:0]  dev_sum;
  logic [REL_SUM_W-1:0]  rel_sum;
  logic [COUNT_BITS-1:0] count;

  // per-request working registers
  logic signed [SAMPLE_W-1:0] x_r;
  logic [SUM_W-1:0]           ns_r;
  logic [MEAN_W-1:0]          old_r;
  logic [MEAN_W-1:0]          mean_r;
  logic [DIFF_W-1:0]          shift_r;
  logic [MLD_W-1:0]           mld_r;
  logic [PROD_W-1:0]          prod_r;
  logic [GAIN_W-1:0]          gain_r;
  logic [REL_W-1:0]           rel_r;
  logic                       full_r;

  // shared divider
  logic              div_start, div_done;
  logic [DIV_W-1:0]  div_dvd, div_q;
  logic [DVS_W-1:0]  div_dvs;

  rmd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_q)
  );

  logic [SUM_W-1:0]     sum_mag, ns_mag, ns_new;
  logic [MEAN_W-1:0]    q_lo;
  logic [DIFF_W-1:0]    shift_d, dev_d, shift_abs, dev_abs;
  logic [DEV_SUM_W:0]   dev_add;
  logic [REL_SUM_W:0]   rel_add;
  logic [PROD_W:0]      prod_full;
  logic                 out_load;

  assign sum_mag = sum_r[SUM_W-1] ? -sum_r : sum_r;
  assign ns_mag  = ns_r[SUM_W-1] ? -ns_r : ns_r;
  assign ns_new  = sum_r + {{(SUM_W-SAMPLE_W){samples.sample[SAMPLE_W-1]}}, samples.sample};
  assign q_lo    = div_q[MEAN_W-1:0];

  assign shift_d   = {old_r[MEAN_W-1], old_r} - {mean_r[MEAN_W-1], mean_r};
  assign dev_d     = {mean_r[MEAN_W-1], mean_r} - {x_r[SAMPLE_W-1], x_r};
  assign shift_abs = shift_d[DIFF_W-1] ? -shift_d : shift_d;
  assign dev_abs   = dev_d[DIFF_W-1] ? -dev_d : dev_d;
  assign dev_add   = {1'b0, dev_sum} + (DEV_SUM_W+1)'(dev_abs);
  assign rel_add   = {1'b0, rel_sum} + (REL_SUM_W+1)'(gain_r);
  assign prod_full = (PROD_W+1)'(shift_r) * (PROD_W+1)'(100);

  // divider operands, picked by the launching state
  always_comb begin
    div_start = 1'b1;
    div_dvd   = '0;
    div_dvs   = '0;
    unique case (state)
      ST_OLD_GO: begin
        div_dvd = DIV_W'(sum_mag);
        div_dvs = DVS_W'(count);
      end
      ST_MEAN_GO: begin
        div_dvd = DIV_W'(ns_mag);
        div_dvs = DVS_W'(count + 1'b1);
      end
      ST_MLD_GO: begin
        div_dvd = DIV_W'(dev_sum);
        div_dvs = DVS_W'(count);
      end
      ST_GAIN_GO: begin
        div_dvd = DIV_W'({prod_r[PROD_W-1:0], {FRAC_BITS{1'b0}}});
        div_dvs = DVS_W'(mld_r);
      end
      ST_REL_GO: begin
        div_dvd = DIV_W'(rel_sum);
        div_dvs = DVS_W'(count);
      end
      default: div_start = 1'b0;
    endcase
  end

  assign samples.ready = (state == ST_IDLE);
  assign out_load      = (state == ST_DONE) && (!results.valid || results.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      sum_r         <= '0;
      dev_sum       <= '0;
      rel_sum       <= '0;
      count         <= '0;
      results.valid <= 1'b0;
    end else begin
      if (out_load) begin
        results.valid <= 1'b1;
      end else if (results.ready) begin
        results.valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (samples.valid) begin
            x_r    <= samples.sample;
            ns_r   <= ns_new;
            full_r <= 1'b0;
            mean_r <= '0;
            mld_r  <= '0;
            rel_r  <= '0;
            if (count == '0) begin
              // first sample seeds the sum
              sum_r   <= ns_new;
              dev_sum <= '0;
              rel_sum <= '0;
              count   <= COUNT_BITS'(1);
              state   <= ST_DONE;
            end else if (count == COUNT_MAX) begin
              full_r <= 1'b1;
              state  <= ST_DONE;
            end else begin
              state <= ST_OLD_GO;
            end
          end
        end
        ST_OLD_GO:  state <= ST_OLD_W;
        ST_OLD_W: begin
          if (div_done) begin
            old_r <= sum_r[SUM_W-1] ? -q_lo : q_lo;
            state <= ST_MEAN_GO;
          end
        end
        ST_MEAN_GO: state <= ST_MEAN_W;
        ST_MEAN_W: begin
          if (div_done) begin
            mean_r <= ns_r[SUM_W-1] ? -q_lo : q_lo;
            state  <= ST_DEV;
          end
        end
        ST_DEV: begin
          shift_r <= shift_abs;
          dev_sum <= dev_add[DEV_SUM_W] ? DEV_MAX : dev_add[DEV_SUM_W-1:0];
          state   <= ST_MLD_GO;
        end
        ST_MLD_GO:  state <= ST_MLD_W;
        ST_MLD_W: begin
          if (div_done) begin
            mld_r <= (div_q[DIV_W-1:MLD_W] != '0) ? '1 : div_q[MLD_W-1:0];
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (mld_r == '0) begin
            gain_r <= FULL_SCORE;
            state  <= ST_REL_ADD;
          end else if (shift_r < DIFF_W'(mld_r)) begin
            prod_r <= prod_full[PROD_W-1:0];
            state  <= ST_GAIN_GO;
          end else begin
            gain_r <= '0;
            state  <= ST_REL_ADD;
          end
        end
        ST_GAIN_GO: state <= ST_GAIN_W;
        ST_GAIN_W: begin
          if (div_done) begin
            gain_r <= FULL_SCORE - div_q[GAIN_W-1:0];
            state  <= ST_REL_ADD;
          end
        end
        ST_REL_ADD: begin
          rel_sum <= rel_add[REL_SUM_W] ? REL_MAX : rel_add[REL_SUM_W-1:0];
          sum_r   <= ns_r;
          count   <= count + 1'b1;
          state   <= ST_REL_GO;
        end
        ST_REL_GO:  state <= ST_REL_W;
        ST_REL_W: begin
          if (div_done) begin
            rel_r <= (div_q[DIV_W-1:REL_W] != '0) ? '1 : div_q[REL_W-1:0];
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      results.mean           <= mean_r;
      results.mean_deviation <= mld_r;
      results.reliability    <= rel_r;
      results.samples_seen   <= SEEN_W'(count);
      results.count_full     <= full_r;
    end
  end

endmodule

// ----- verif/running_mean_deviation_reliability_tb.sv -----
// Self-checking testbench for the running mean / deviation / reliability block.
module running_mean_deviation_reliability_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rmd_pkg::*;

  localparam int RANDOM_SAMPLES = 530;
  localparam int CYCLE_LIMIT    = 600000;  // worst case for all ~550 samples, plus long hold
  localparam int DRAIN_CYCLES   = 400;
  localparam int HOLD_CYCLES    = 3000;
  localparam logic [63:0] COUNT_LIMIT = (64'd1 << COUNT_BITS) - 64'd1;
  localparam logic [63:0] DEV_LIMIT   = (64'd1 << DEV_SUM_W) - 64'd1;
  localparam logic [63:0] REL_LIMIT   = (64'd1 << REL_SUM_W) - 64'd1;
  localparam logic [63:0] SCORE_FULL  = 64'd100 << FRAC_BITS;

  typedef struct packed {
    logic signed [MEAN_W-1:0] mean;
    logic [MLD_W-1:0]         mld;
    logic [REL_W-1:0]         rel;
    logic [SEEN_W-1:0]        seen;
    logic                     full;
  } stats_t;

  // One row of the directed table. Rows with a typed answer override the predictor.
  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    bit                         typed;
    stats_t                     answer;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rmd_in_if  samples();
  rmd_out_if results();

  running_mean_deviation_reliability dut (
    .clk     (clk),
    .rst     (rst),
    .samples (samples.sink),
    .results (results.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 0;
  end

  // Predictor state: sums kept two's complement in 64 bits.
  logic [63:0] sum_acc = '0;
  logic [63:0] dev_acc = '0;
  logic [63:0] rel_acc = '0;
  logic [63:0] cnt     = '0;

  stats_t stats_q[$];        // expected results, oldest first
  bit     typed_q[$];        // per queued request: does a typed answer follow
  stats_t answer_q[$];
  int     errors = 0;
  int     got    = 0;
  bit     sending_done = 0;
  int     cycles = 0;

  function automatic logic [63:0] magnitude(logic [63:0] v);
    return v[63] ? -v : v;
  endfunction

  // Truncating divide of a signed 64-bit value by a positive count.
  function automatic logic [63:0] div_trunc(logic [63:0] num, logic [63:0] den);
    logic [63:0] q;
    q = magnitude(num) / den;
    return num[63] ? -q : q;
  endfunction

  function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b, logic [63:0] lim);
    if (a > lim || b > lim - a) return lim;
    return a + b;
  endfunction

  function automatic stats_t track_sample(logic signed [SAMPLE_W-1:0] s);
    stats_t      r;
    logic [63:0] x, old_mean, new_sum, new_mean, shift, dev, mld, gain, rel;
    r = '0;
    x = {{32{s[SAMPLE_W-1]}}, s};
    if (cnt == 0) begin
      // first sample seeds the sum only
      sum_acc = x;
      dev_acc = '0;
      rel_acc = '0;
      cnt     = 1;
    end else if (cnt >= COUNT_LIMIT) begin
      r.full = 1'b1;
    end else begin
      old_mean = div_trunc(sum_acc, cnt);
      new_sum  = sum_acc + x;
      new_mean = div_trunc(new_sum, cnt + 1);
      shift    = magnitude(old_mean - new_mean);
      dev      = magnitude(new_mean - x);
      dev_acc  = add_sat(dev_acc, dev, DEV_LIMIT);
      mld      = dev_acc / cnt;
      if (mld > 64'hFFFF_FFFF) mld = 64'hFFFF_FFFF;
      gain = 0;
      if (mld == 0) gain = SCORE_FULL;
      else if (shift < mld) gain = SCORE_FULL - (SCORE_FULL * shift) / mld;
      rel_acc = add_sat(rel_acc, gain, REL_LIMIT);
      sum_acc = new_sum;
      cnt     = cnt + 1;
      rel     = rel_acc / cnt;
      if (rel > 64'h7F_FFFF) rel = 64'h7F_FFFF;
      r.mean = new_mean[MEAN_W-1:0];
      r.mld  = mld[MLD_W-1:0];
      r.rel  = rel[REL_W-1:0];
    end
    r.seen = cnt[SEEN_W-1:0];
    return r;
  endfunction

  // Accepted sample requests feed the predictor.
  always @(posedge clk) begin
    stats_t p;
    if (!rst && samples.valid && samples.ready) begin
      p = track_sample(samples.sample);
      if (typed_q.pop_front()) p = answer_q.pop_front();
      stats_q.push_back(p);
    end
  end

  // Accepted result requests are checked against the oldest expectation.
  always @(posedge clk) begin
    stats_t e;
    if (!rst && results.valid && results.ready) begin
      got <= got + 1;
      if (stats_q.size() == 0) begin
        $display("%0t: unexpected result mean=%0d mld=%0d rel=%0d seen=%0d full=%0b", $time,
                 results.mean, results.mean_deviation, results.reliability,
                 results.samples_seen, results.count_full);
        errors <= errors + 1;
      end else begin
        e = stats_q.pop_front();
        if (results.mean !== e.mean || results.mean_deviation !== e.mld ||
            results.reliability !== e.rel || results.samples_seen !== e.seen ||
            results.count_full !== e.full) begin
          $display("%0t: mismatch expected mean=%0d mld=%0d rel=%0d seen=%0d full=%0b",
                   $time, e.mean, e.mld, e.rel, e.seen, e.full);
          $display("%0t:          actual   mean=%0d mld=%0d rel=%0d seen=%0d full=%0b",
                   $time, results.mean, results.mean_deviation, results.reliability,
                   results.samples_seen, results.count_full);
          errors <= errors + 1;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off so the block backs up.
  initial begin
    int  stall;
    bit  held;
    held = 0;
    results.ready = 1'b0;
    @(negedge rst);
    forever begin
      if (!held && got >= 40) begin
        held = 1;
        results.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        results.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      results.ready <= 1'b1;
      do @(posedge clk); while (!(results.valid && results.ready));
    end
  end

  row_t dir_rows[$];
  int   gap_next;

  // Offer one sample; valid stays up across back-to-back requests.
  task automatic offer_sample(logic signed [SAMPLE_W-1:0] s, bit typed, stats_t answer);
    typed_q.push_back(typed);
    if (typed) answer_q.push_back(answer);
    samples.valid  <= 1'b1;
    samples.sample <= s;
    do @(posedge clk); while (!(samples.valid && samples.ready));
    gap_next = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
    if (gap_next > 0) begin
      samples.valid <= 1'b0;
      repeat (gap_next) @(posedge clk);
    end
  endtask

  function automatic row_t mk_row(logic signed [SAMPLE_W-1:0] s);
    row_t r;
    r.sample = s;
    r.typed  = 0;
    r.answer = '0;
    return r;
  endfunction

  initial begin
    row_t                       r;
    logic signed [SAMPLE_W-1:0] level, s, prev;
    int                         spread, pick;
    samples.valid  = 1'b0;
    samples.sample = '0;

    // First sample after reset: zeros with a count of one.
    r = mk_row(32'sh0001_8000);
    r.typed = 1;
    r.answer.seen = 1;
    dir_rows.push_back(r);
    // Repeats of the same value: zero deviation, full score.
    dir_rows.push_back(mk_row(32'sh0001_8000));
    dir_rows.push_back(mk_row(32'sh0001_8000));
    // Field extremes and sign flips
    dir_rows.push_back(mk_row(32'sh7FFF_FFFF));
    dir_rows.push_back(mk_row(32'sh8000_0000));
    dir_rows.push_back(mk_row(32'sh7FFF_FFFF));
    dir_rows.push_back(mk_row(32'sh8000_0000));
    dir_rows.push_back(mk_row(32'sh0000_0000));
    dir_rows.push_back(mk_row(-32'sd1));
    dir_rows.push_back(mk_row(32'sd1));
    dir_rows.push_back(mk_row(32'sh0000_0000));
    // Settling around a level: small shift against the mld
    dir_rows.push_back(mk_row(32'sh0000_0000));
    dir_rows.push_back(mk_row(32'sh0000_0100));
    dir_rows.push_back(mk_row(-32'sh0000_0100));
    dir_rows.push_back(mk_row(32'sh0000_0000));
    dir_rows.push_back(mk_row(32'sh0000_0080));
    dir_rows.push_back(mk_row(32'sh7FFF_0000));
    dir_rows.push_back(mk_row(32'sh0000_0000));
    dir_rows.push_back(mk_row(-32'sh0001_0000));

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) offer_sample(dir_rows[i].sample, dir_rows[i].typed,
                                       dir_rows[i].answer);

    // Random part: mostly noisy readings around a drifting level, some wild values.
    level = $urandom;
    prev  = level;
    spread = 256;
    for (int n = 0; n < RANDOM_SAMPLES; n++) begin
      if ($urandom_range(0, 29) == 0) level = $urandom;
      if ($urandom_range(0, 19) == 0) spread = 1 << $urandom_range(0, 30);
      pick = $urandom_range(0, 9);
      if (pick == 0)      s = $urandom;
      else if (pick == 1) s = prev;
      else                s = level + $signed($urandom_range(0, 2 * spread)) - spread;
      prev = s;
      offer_sample(s, 0, '0);
    end
    samples.valid <= 1'b0;
    sending_done = 1;

    while (stats_q.size() != 0 || typed_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/rmd_pkg.sv
hdl/rmd_in_if.sv
hdl/rmd_out_if.sv
hdl/rmd_div.sv
hdl/running_mean_deviation_reliability.sv
verif/running_mean_deviation_reliability_tb.sv
